FILE: rtl/i2c_master_bit_sequencer_unit_defines.svh
// Assertion macros for the I2C bit sequencer
`ifndef I2C_MASTER_BIT_SEQUENCER_UNIT_DEFINES_SVH
`define I2C_MASTER_BIT_SEQUENCER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define I2CBS_CHK_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define I2CBS_CHK_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/i2cbs_pkg.sv
// Shared types, codes and step tables of the I2C bit sequencer
package i2cbs_pkg;

	typedef enum logic [2:0] {
		CMD_START    = 3'd0,
		CMD_STOP     = 3'd1,
		CMD_WRITE    = 3'd2,
		CMD_READ     = 3'd3,
		CMD_SEND_ACK = 3'd4,
		CMD_WAIT_ACK = 3'd5
	} cmd_e;

	typedef enum logic [2:0] {
		OP_SCL0   = 3'd0,
		OP_SCL1   = 3'd1,
		OP_SDA0   = 3'd2,
		OP_SDA1   = 3'd3,
		OP_SDAB   = 3'd4,
		OP_DLY    = 3'd5,
		OP_DLYRX  = 3'd6,
		OP_DLYACK = 3'd7
	} op_e;

	localparam logic [2:0] BIT_LAST = 3'd7;
	localparam logic [15:0] DELAY_RESET = 16'd100;

	// classified beat handed from front to back
	typedef struct packed {
		logic       start;
		cmd_e       cmd;
		logic [7:0] tx;
		logic       ack;
		logic       sda;
	} item_t;

	// line and status snapshot after one tick
	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       busy;
		logic       done;
		logic [7:0] rx;
		logic       ack;
	} res_t;

	function automatic op_e prog_op(input cmd_e c, input logic [2:0] s);
		op_e op;
		op = OP_SCL0;
		case (c)
			CMD_START: begin
				case (s)
					3'd0: op = OP_SDA1;
					3'd1: op = OP_SCL1;
					3'd2: op = OP_SDA0;
					3'd3: op = OP_DLY;
					default: op = OP_SCL0;
				endcase
			end
			CMD_STOP: begin
				case (s)
					3'd0: op = OP_SDA0;
					3'd1: op = OP_DLY;
					3'd2: op = OP_SCL1;
					3'd3: op = OP_DLY;
					3'd4: op = OP_SDA1;
					default: op = OP_SCL0;
				endcase
			end
			CMD_WRITE: begin
				case (s)
					3'd1: op = OP_SDAB;
					3'd2: op = OP_DLY;
					3'd3: op = OP_SCL1;
					3'd4: op = OP_DLY;
					default: op = OP_SCL0;
				endcase
			end
			CMD_READ: begin
				case (s)
					3'd0: op = OP_SDA1;
					3'd1: op = OP_DLY;
					3'd2: op = OP_SCL1;
					3'd3: op = OP_DLYRX;
					3'd5: op = OP_DLY;
					default: op = OP_SCL0;
				endcase
			end
			CMD_SEND_ACK: begin
				case (s)
					3'd0: op = OP_SDAB;
					3'd1: op = OP_DLY;
					3'd2: op = OP_SCL1;
					3'd3: op = OP_DLY;
					default: op = OP_SCL0;
				endcase
			end
			CMD_WAIT_ACK: begin
				case (s)
					3'd0: op = OP_SDA1;
					3'd1: op = OP_DLY;
					3'd2: op = OP_SCL1;
					3'd3: op = OP_DLYACK;
					default: op = OP_SCL0;
				endcase
			end
			default: op = OP_SCL0;
		endcase
		return op;
	endfunction

	function automatic logic [2:0] prog_len(input cmd_e c);
		logic [2:0] n;
		case (c)
			CMD_WRITE, CMD_READ: n = 3'd6;
			default: n = 3'd5;
		endcase
		return n;
	endfunction

	function automatic logic has_loop(input cmd_e c);
		return (c == CMD_WRITE) || (c == CMD_READ);
	endfunction

	function automatic logic [2:0] loop_start(input cmd_e c);
		logic [2:0] n;
		case (c)
			CMD_READ: n = 3'd2;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

	function automatic logic [2:0] loop_end(input cmd_e c);
		logic [2:0] n;
		case (c)
			CMD_READ: n = 3'd5;
			default: n = 3'd4;
		endcase
		return n;
	endfunction

endpackage

FILE: rtl/i2cbs_fifo.sv
// Two-entry queue with registered occupancy
module i2cbs_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         rd,
	output logic [W-1:0] rdata,
	output logic         empty
);
	logic [W-1:0] mem_q [2];
	logic         wptr_q;
	logic         rptr_q;
	logic [1:0]   count_q;
	logic         do_wr;
	logic         do_rd;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_wr) begin
				wptr_q <= ~wptr_q;
			end
			if (do_rd) begin
				rptr_q <= ~rptr_q;
			end
			case ({do_wr, do_rd})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

FILE: rtl/i2cbs_front.sv
// Front end: classifies each input beat and queues it for the sequencer
module i2cbs_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic                cmd_valid,
	input  logic [2:0]          command,
	input  logic [7:0]          tx_byte,
	input  logic                ack_level,
	input  logic                sda_sample,
	input  logic                take,
	output logic                avail,
	output i2cbs_pkg::item_t    item
);
	i2cbs_pkg::item_t cls;
	logic             q_empty;

	// codes above wait-ack mean nothing and never start a sequence
	always_comb begin
		cls.start = cmd_valid && (command <= 3'(i2cbs_pkg::CMD_WAIT_ACK));
		cls.cmd   = i2cbs_pkg::cmd_e'(command);
		cls.tx    = tx_byte;
		cls.ack   = ack_level;
		cls.sda   = sda_sample;
	end

	i2cbs_fifo #(
		.W($bits(i2cbs_pkg::item_t))
	) u_inq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (push),
		.wdata  (cls),
		.full   (full),
		.rd     (take),
		.rdata  (item),
		.empty  (q_empty)
	);

	assign avail = !q_empty;
endmodule

FILE: rtl/i2cbs_seq.sv
// Back end: runs one bus tick per beat through the command step tables
module i2cbs_seq #(
	parameter int DELAY_WIDTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  i2cbs_pkg::item_t item,
	input  logic [15:0]      delay_ticks,
	output i2cbs_pkg::res_t  res
);
	localparam int EW = (DELAY_WIDTH > 16) ? DELAY_WIDTH : 16;
	localparam logic [EW-1:0] CAP = EW'({DELAY_WIDTH{1'b1}});

	logic                   running_q;
	i2cbs_pkg::cmd_e        cmd_q;
	logic [2:0]             step_q;
	logic [2:0]             bit_q;
	logic [DELAY_WIDTH-1:0] dcnt_q;
	logic [7:0]             shift_q;
	logic                   scl_q;
	logic                   sda_q;
	logic                   ack_q;
	logic [7:0]             rx_q;

	logic                   run_n;
	i2cbs_pkg::cmd_e        cmd_n;
	logic [2:0]             step_n;
	logic [2:0]             bit_n;
	logic [DELAY_WIDTH-1:0] dcnt_n;
	logic [7:0]             shift_n;
	logic                   scl_n;
	logic                   sda_n;
	logic                   ack_n;
	logic [7:0]             rx_n;
	logic                   done_n;
	logic                   step_end;
	i2cbs_pkg::op_e         op;
	logic [EW-1:0]          eff;
	logic [EW:0]            inc;

	// zero acts as one, and the delay saturates at the counter's range
	always_comb begin
		eff = EW'(delay_ticks);
		if (eff == '0) begin
			eff = EW'(1);
		end
		if (eff > CAP) begin
			eff = CAP;
		end
	end

	always_comb begin
		run_n    = running_q;
		cmd_n    = cmd_q;
		step_n   = step_q;
		bit_n    = bit_q;
		dcnt_n   = dcnt_q;
		shift_n  = shift_q;
		scl_n    = scl_q;
		sda_n    = sda_q;
		ack_n    = ack_q;
		rx_n     = rx_q;
		done_n   = 1'b0;
		step_end = 1'b1;
		inc      = '0;
		op       = i2cbs_pkg::OP_SCL0;

		if (!running_q && item.start) begin
			run_n  = 1'b1;
			cmd_n  = item.cmd;
			step_n = 3'd0;
			bit_n  = 3'd0;
			dcnt_n = '0;
			case (item.cmd)
				i2cbs_pkg::CMD_WRITE:    shift_n = item.tx;
				i2cbs_pkg::CMD_SEND_ACK: shift_n = {item.ack, 7'd0};
				default:                 shift_n = 8'd0;
			endcase
		end

		if (run_n) begin
			op = i2cbs_pkg::prog_op(cmd_n, step_n);
			case (op)
				i2cbs_pkg::OP_SCL0: scl_n = 1'b0;
				i2cbs_pkg::OP_SCL1: scl_n = 1'b1;
				i2cbs_pkg::OP_SDA0: sda_n = 1'b0;
				i2cbs_pkg::OP_SDA1: sda_n = 1'b1;
				i2cbs_pkg::OP_SDAB: begin
					sda_n   = shift_n[7];
					shift_n = {shift_n[6:0], 1'b0};
				end
				default: begin
					inc = (EW+1)'(dcnt_n) + (EW+1)'(1);
					if (inc < {1'b0, eff}) begin
						step_end = 1'b0;
						dcnt_n   = inc[DELAY_WIDTH-1:0];
					end else begin
						dcnt_n = '0;
						if (op == i2cbs_pkg::OP_DLYRX) begin
							shift_n = {shift_n[6:0], item.sda};
						end else if (op == i2cbs_pkg::OP_DLYACK) begin
							ack_n = item.sda;
						end
					end
				end
			endcase

			if (step_end) begin
				if (i2cbs_pkg::has_loop(cmd_n) && step_n == i2cbs_pkg::loop_end(cmd_n)
						&& bit_n != i2cbs_pkg::BIT_LAST) begin
					bit_n  = bit_n + 3'd1;
					step_n = i2cbs_pkg::loop_start(cmd_n);
				end else if (step_n + 3'd1 >= i2cbs_pkg::prog_len(cmd_n)) begin
					run_n  = 1'b0;
					done_n = 1'b1;
					step_n = 3'd0;
					if (cmd_n == i2cbs_pkg::CMD_READ) begin
						rx_n = shift_n;
					end
				end else begin
					step_n = step_n + 3'd1;
				end
			end
		end

		res.scl  = scl_n;
		res.sda  = sda_n;
		res.busy = run_n;
		res.done = done_n;
		res.rx   = rx_n;
		res.ack  = ack_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			cmd_q     <= i2cbs_pkg::CMD_START;
			step_q    <= 3'd0;
			bit_q     <= 3'd0;
			dcnt_q    <= '0;
			shift_q   <= 8'd0;
			scl_q     <= 1'b1;
			sda_q     <= 1'b1;
			ack_q     <= 1'b0;
			rx_q      <= 8'd0;
		end else if (fire) begin
			running_q <= run_n;
			cmd_q     <= cmd_n;
			step_q    <= step_n;
			bit_q     <= bit_n;
			dcnt_q    <= dcnt_n;
			shift_q   <= shift_n;
			scl_q     <= scl_n;
			sda_q     <= sda_n;
			ack_q     <= ack_n;
			rx_q      <= rx_n;
		end
	end
endmodule

FILE: rtl/i2c_master_bit_sequencer_unit.sv
// A result enters the result queue at the edge that takes its input beat and can be
// popped from the next cycle if none is ahead of it. Throughput: one beat per cycle
// while a beat waits and the result queue has room; the sequencer does one bus tick per
// beat and the two-entry queues on either side let input and output stall on their own.
// Reset (arst_n low, asynchronous): queues empty, sequencer idle, both lines
// released, delay register back to 100 ticks.
// Top level of the I2C bit sequencer
`include "i2c_master_bit_sequencer_unit_defines.svh"

module i2c_master_bit_sequencer_unit #(
	parameter int DELAY_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        cmd_valid,
	input  logic [2:0]  command,
	input  logic [7:0]  tx_byte,
	input  logic        ack_level,
	input  logic        sda_sample,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	output logic        empty,
	input  logic        pop,
	output logic        scl_level,
	output logic        sda_level,
	output logic        busy_res,
	output logic        done_res,
	output logic [7:0]  rx_byte,
	output logic        ack_seen
);
	logic [15:0]      delay_q;
	logic             fe_avail;
	i2cbs_pkg::item_t fe_item;
	i2cbs_pkg::res_t  seq_res;
	i2cbs_pkg::res_t  out_res;
	logic             res_full;
	logic             fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= i2cbs_pkg::DELAY_RESET;
		end else if (cfg_we) begin
			delay_q <= cfg_data;
		end
	end

	i2cbs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.cmd_valid  (cmd_valid),
		.command    (command),
		.tx_byte    (tx_byte),
		.ack_level  (ack_level),
		.sda_sample (sda_sample),
		.take       (fire),
		.avail      (fe_avail),
		.item       (fe_item)
	);

	// one bus tick per beat, only when the result has somewhere to go
	assign fire = fe_avail && !res_full;

	i2cbs_seq #(
		.DELAY_WIDTH(DELAY_WIDTH)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.item        (fe_item),
		.delay_ticks (delay_q),
		.res         (seq_res)
	);

	i2cbs_fifo #(
		.W($bits(i2cbs_pkg::res_t))
	) u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (fire),
		.wdata  (seq_res),
		.full   (res_full),
		.rd     (pop),
		.rdata  (out_res),
		.empty  (empty)
	);

	assign scl_level = out_res.scl;
	assign sda_level = out_res.sda;
	assign busy_res  = out_res.busy;
	assign done_res  = out_res.done;
	assign rx_byte   = out_res.rx;
	assign ack_seen  = out_res.ack;

	`I2CBS_CHK_NOW(a_done_not_busy, !empty && done_res, !busy_res, "done beat still busy")
	`I2CBS_CHK_NOW(a_fire_has_item, fire, fe_avail && !res_full, "tick without item or room")
	`I2CBS_CHK_NXT(a_cfg_taken, cfg_we, delay_q == $past(cfg_data), "delay write lost")
	`I2CBS_CHK_NXT(a_fire_fills, fire && !(pop && !empty), !empty, "result beat lost")
endmodule
